// ===== design/small_language_lexer_top_defines.svh =====
// Assertion macros for the lexer. Define NO_ASSERTIONS to compile them away.
`ifndef SMALL_LANGUAGE_LEXER_TOP_DEFINES_SVH
`define SMALL_LANGUAGE_LEXER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset.
`define SLL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("small_language_lexer: check failed");
// Condition in one cycle that implies a consequence in the next.
`define SLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("small_language_lexer: check failed");
`else
`define SLL_ASSERT(lbl, clk, rstn, prop)
`define SLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/sll_pkg.sv =====
`default_nettype none

package sll_pkg;

    localparam int MAX_IDENT_DEF = 127;
    localparam int POS_W  = 16;
    localparam int KIND_W = 5;
    localparam int MODE_W = 3;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // scanner modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LT     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EQ     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BANG   = 3'd6;

    // token kinds
    localparam logic [KIND_W-1:0] K_NUMBER    = 5'd0;
    localparam logic [KIND_W-1:0] K_IDENT     = 5'd1;
    localparam logic [KIND_W-1:0] K_PLUS      = 5'd2;
    localparam logic [KIND_W-1:0] K_MINUS     = 5'd3;
    localparam logic [KIND_W-1:0] K_TIMES     = 5'd4;
    localparam logic [KIND_W-1:0] K_DIV       = 5'd5;
    localparam logic [KIND_W-1:0] K_MOD       = 5'd6;
    localparam logic [KIND_W-1:0] K_GT        = 5'd7;
    localparam logic [KIND_W-1:0] K_GEQ       = 5'd8;
    localparam logic [KIND_W-1:0] K_LT        = 5'd9;
    localparam logic [KIND_W-1:0] K_LEQ       = 5'd10;
    localparam logic [KIND_W-1:0] K_EQ        = 5'd11;
    localparam logic [KIND_W-1:0] K_NEQ       = 5'd12;
    localparam logic [KIND_W-1:0] K_BECOMES   = 5'd13;
    localparam logic [KIND_W-1:0] K_LPAREN    = 5'd14;
    localparam logic [KIND_W-1:0] K_RPAREN    = 5'd15;
    localparam logic [KIND_W-1:0] K_LBRACE    = 5'd16;
    localparam logic [KIND_W-1:0] K_RBRACE    = 5'd17;
    localparam logic [KIND_W-1:0] K_COMMA     = 5'd18;
    localparam logic [KIND_W-1:0] K_SEMICOLON = 5'd19;
    localparam logic [KIND_W-1:0] K_RESERVED0 = 5'd20;
    localparam logic [KIND_W-1:0] K_END       = 5'd28;
    localparam logic [KIND_W-1:0] K_ILLEGAL   = 5'd29;

    // output register sources
    localparam logic [1:0] SRC_A      = 2'd0;
    localparam logic [1:0] SRC_B_NOW  = 2'd1;
    localparam logic [1:0] SRC_B_HELD = 2'd2;
    localparam logic [1:0] SRC_CHUNK  = 2'd3;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // reserved words, first character in the low byte
    localparam logic [63:0] KW_TEXT [0:7] = '{
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6c65,   // else
        64'h0000_0065_6c69_6877,   // while
        64'h0000_6e72_7574_6572,   // return
        64'h0000_0000_0072_6176,   // var
        64'h0000_0000_006e_7566,   // fun
        64'h0000_0000_6469_6f76,   // void
        64'h0000_0000_0074_6e69    // int
    };
    localparam logic [3:0] KW_LEN [0:7] = '{
        4'd2, 4'd4, 4'd5, 4'd6, 4'd3, 4'd3, 4'd4, 4'd3
    };

    typedef struct packed {
        logic       accept;
        logic       load;
        logic [1:0] src;
        logic       last;
        logic       rd;
        logic       k_clr;
        logic       k_inc;
        logic       wr_first;
    } cmd_t;

    typedef struct packed {
        logic a_simple;
        logic a_ident;
        logic b_valid;
        logic chunk_final;
    } sts_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // keep the low n bytes of a word
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // {hit, kind} for a held identifier head
    function automatic logic [KIND_W:0] kw_lookup(input logic [63:0] head,
                                                  input logic [7:0]  len);
        logic [KIND_W:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (len == {4'd0, KW_LEN[k]} &&
                (head & byte_mask(KW_LEN[k])) == KW_TEXT[k]) begin
                r = {1'b1, K_RESERVED0 + KIND_W'(k)};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sll_datapath.sv =====
`default_nettype none

module sll_datapath
    import sll_pkg::*;
#(
    parameter int MAX_IDENT = MAX_IDENT_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire  [7:0]              s_in_byte,
    input  wire                     s_end_mark,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic [KIND_W-1:0]       m_kind,
    output logic signed [31:0]      m_number_value,
    output logic [POS_W-1:0]        m_start_row,
    output logic [POS_W-1:0]        m_start_col,
    output logic [63:0]             m_text_chunk,
    output logic [3:0]              m_text_bytes,
    output logic                    m_token_done,
    output logic                    m_last
);

    localparam int LW    = $clog2(MAX_IDENT + 1);
    localparam int RW    = LW - 3;
    localparam int NROWS = 2 ** RW;

    // scanner state
    logic [MODE_W-1:0] mode_reg;
    logic [LW-1:0]     len_reg;
    logic [31:0]       accum_reg;
    logic [POS_W-1:0]  tok_row_reg, tok_col_reg, cur_row_reg, cur_col_reg;
    logic [63:0]       head_reg;

    // identifier flush context
    logic [LW-1:0]     fl_len_reg;
    logic [POS_W-1:0]  fl_row_reg, fl_col_reg;
    logic [7:0]        hold_byte_reg;
    logic              hold_wr_reg;
    logic [RW-1:0]     k_reg, k_next;
    logic [63:0]       rdata_reg;

    // second result held across a flush
    logic [KIND_W-1:0] b_kind_reg;
    logic [POS_W-1:0]  b_row_reg, b_col_reg;

    // output register
    logic [KIND_W-1:0] kind_reg;
    logic [31:0]       num_reg;
    logic [POS_W-1:0]  row_reg, col_reg;
    logic [63:0]       chunk_reg;
    logic [3:0]        bytes_reg;
    logic              done_reg, last_reg;

    logic [63:0]       store_mem [0:NROWS-1];

    // decode
    logic [POS_W-1:0]  row_n, col_n, col_inc;
    logic              word;
    logic [MODE_W-1:0] st_mode;
    logic              st_emit;
    logic [KIND_W-1:0] st_kind;
    logic [KIND_W:0]   kw_res;
    logic              flush_now, too_long, pair_done, ident_keep, num_keep, apply_start;
    logic              a_ident, a_simple, b_valid;
    logic [KIND_W-1:0] a_kind, b_kind;
    logic [31:0]       a_num, accum_step;
    logic [POS_W-1:0]  b_row, b_col;
    logic              now_wr, wr_en;
    logic [RW-1:0]     wr_row;
    logic [2:0]        wr_lane;
    logic [7:0]        wr_data;
    logic [LW-1:0]     rem;
    logic              chunk_final;
    logic [3:0]        chunk_n;

    assign word    = is_alpha(s_in_byte) || is_digit(s_in_byte) || s_in_byte == "_";
    assign col_inc = sat_inc(cur_col_reg);
    assign col_n   = (s_in_byte == CH_LF) ? '0 : col_inc;
    assign row_n   = (s_in_byte == CH_LF) ? sat_inc(cur_row_reg) : cur_row_reg;
    assign kw_res  = kw_lookup(head_reg, 8'(len_reg));
    assign accum_step = {accum_reg[28:0], 3'b000} + {accum_reg[30:0], 1'b0}
                      + 32'(s_in_byte[3:0]);

    // what a byte does when it opens a token
    always_comb begin
        st_mode = MODE_IDLE;
        st_emit = 1'b0;
        st_kind = K_ILLEGAL;
        if (is_alpha(s_in_byte) || s_in_byte == "_") begin
            st_mode = MODE_IDENT;
        end else if (is_digit(s_in_byte)) begin
            st_mode = MODE_NUMBER;
        end else if (!is_space(s_in_byte)) begin
            st_emit = 1'b1;
            unique case (s_in_byte)
                ">": begin st_mode = MODE_GT;   st_emit = 1'b0; end
                "<": begin st_mode = MODE_LT;   st_emit = 1'b0; end
                "=": begin st_mode = MODE_EQ;   st_emit = 1'b0; end
                "!": begin st_mode = MODE_BANG; st_emit = 1'b0; end
                "+": st_kind = K_PLUS;
                "-": st_kind = K_MINUS;
                "*": st_kind = K_TIMES;
                "/": st_kind = K_DIV;
                "%": st_kind = K_MOD;
                "(": st_kind = K_LPAREN;
                ")": st_kind = K_RPAREN;
                "{": st_kind = K_LBRACE;
                "}": st_kind = K_RBRACE;
                ",": st_kind = K_COMMA;
                ";": st_kind = K_SEMICOLON;
                default: st_kind = K_ILLEGAL;
            endcase
        end
    end

    // what the pending token does with this item
    always_comb begin
        flush_now  = 1'b0;
        too_long   = 1'b0;
        pair_done  = 1'b0;
        ident_keep = 1'b0;
        num_keep   = 1'b0;
        unique case (mode_reg) inside
            MODE_IDENT: begin
                if (s_end_mark || !word)            flush_now  = 1'b1;
                else if (len_reg >= LW'(MAX_IDENT)) too_long   = 1'b1;
                else                                ident_keep = 1'b1;
            end
            MODE_NUMBER: begin
                if (s_end_mark || !is_digit(s_in_byte)) flush_now = 1'b1;
                else                                    num_keep  = 1'b1;
            end
            MODE_GT, MODE_LT, MODE_EQ, MODE_BANG: begin
                if (s_end_mark || s_in_byte != "=") flush_now = 1'b1;
                else                                pair_done = 1'b1;
            end
            default: flush_now = 1'b0;
        endcase
        apply_start = !s_end_mark && !ident_keep && !num_keep && !pair_done;

        a_ident  = flush_now && mode_reg == MODE_IDENT && !kw_res[KIND_W];
        a_simple = (flush_now && !a_ident) || too_long || pair_done;
        a_num    = (flush_now && mode_reg == MODE_NUMBER) ? accum_reg : '0;

        a_kind = K_ILLEGAL;
        if (too_long) begin
            a_kind = K_ILLEGAL;
        end else if (pair_done) begin
            unique case (mode_reg) inside
                MODE_GT: a_kind = K_GEQ;
                MODE_LT: a_kind = K_LEQ;
                MODE_EQ: a_kind = K_EQ;
                default: a_kind = K_NEQ;
            endcase
        end else begin
            unique case (mode_reg) inside
                MODE_IDENT:  a_kind = kw_res[KIND_W-1:0];
                MODE_NUMBER: a_kind = K_NUMBER;
                MODE_GT:     a_kind = K_GT;
                MODE_LT:     a_kind = K_LT;
                MODE_EQ:     a_kind = K_BECOMES;
                default:     a_kind = K_ILLEGAL;
            endcase
        end

        if (s_end_mark) begin
            b_valid = 1'b1;
            b_kind  = K_END;
            b_row   = cur_row_reg;
            b_col   = col_inc;
        end else begin
            b_valid = apply_start && st_emit;
            b_kind  = st_kind;
            b_row   = row_n;
            b_col   = col_n;
        end
    end

    assign sts.a_simple    = a_simple;
    assign sts.a_ident     = a_ident;
    assign sts.b_valid     = b_valid;
    assign sts.chunk_final = chunk_final;

    // chunk bookkeeping
    assign rem         = fl_len_reg - {k_reg, 3'b000};
    assign chunk_final = rem <= LW'(8);
    assign chunk_n     = chunk_final ? rem[3:0] : 4'd8;
    assign k_next      = cmd.k_clr ? '0 : (cmd.k_inc ? k_reg + 1'b1 : k_reg);

    // store write: continuing identifier, fresh identifier, or deferred first byte
    assign now_wr  = cmd.accept &&
                     (ident_keep || (apply_start && st_mode == MODE_IDENT && !a_ident));
    assign wr_en   = now_wr || (cmd.wr_first && hold_wr_reg);
    assign wr_row  = (now_wr && ident_keep) ? len_reg[LW-1:3] : '0;
    assign wr_lane = (now_wr && ident_keep) ? len_reg[2:0] : 3'd0;
    assign wr_data = now_wr ? s_in_byte : hold_byte_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_row][8*wr_lane +: 8] <= wr_data;
        end
        if (cmd.rd) begin
            rdata_reg <= store_mem[k_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            len_reg     <= '0;
            accum_reg   <= '0;
            tok_row_reg <= POS_W'(1);
            tok_col_reg <= POS_W'(1);
            cur_row_reg <= POS_W'(1);
            cur_col_reg <= '0;
            hold_wr_reg <= 1'b0;
        end else if (cmd.accept) begin
            if (s_end_mark) begin
                mode_reg    <= MODE_IDLE;
                len_reg     <= '0;
                accum_reg   <= '0;
                tok_row_reg <= POS_W'(1);
                tok_col_reg <= POS_W'(1);
                cur_row_reg <= POS_W'(1);
                cur_col_reg <= '0;
            end else begin
                cur_row_reg <= row_n;
                cur_col_reg <= col_n;
                if (apply_start) begin
                    mode_reg  <= st_mode;
                    len_reg   <= (st_mode == MODE_IDENT) ? LW'(1) : '0;
                    accum_reg <= (st_mode == MODE_NUMBER) ? 32'(s_in_byte[3:0]) : '0;
                    if (!is_space(s_in_byte)) begin
                        tok_row_reg <= row_n;
                        tok_col_reg <= col_n;
                    end
                end else if (pair_done) begin
                    mode_reg <= MODE_IDLE;
                end else if (ident_keep) begin
                    len_reg <= len_reg + 1'b1;
                end else if (num_keep) begin
                    accum_reg <= accum_step;
                end
            end
            hold_wr_reg <= a_ident && apply_start && st_mode == MODE_IDENT;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.accept) begin
            if (apply_start) begin
                head_reg[7:0] <= s_in_byte;
            end else if (ident_keep && len_reg < LW'(8)) begin
                head_reg[8*len_reg[2:0] +: 8] <= s_in_byte;
            end
            b_kind_reg <= b_kind;
            b_row_reg  <= b_row;
            b_col_reg  <= b_col;
            if (a_ident) begin
                fl_len_reg    <= len_reg;
                fl_row_reg    <= tok_row_reg;
                fl_col_reg    <= tok_col_reg;
                hold_byte_reg <= s_in_byte;
            end
        end
        if (cmd.load) begin
            last_reg <= cmd.last;
            case (cmd.src)
                SRC_A: begin
                    kind_reg  <= a_kind;
                    num_reg   <= a_num;
                    row_reg   <= tok_row_reg;
                    col_reg   <= tok_col_reg;
                    chunk_reg <= '0;
                    bytes_reg <= 4'd0;
                    done_reg  <= 1'b1;
                end
                SRC_B_NOW: begin
                    kind_reg  <= b_kind;
                    num_reg   <= '0;
                    row_reg   <= b_row;
                    col_reg   <= b_col;
                    chunk_reg <= '0;
                    bytes_reg <= 4'd0;
                    done_reg  <= 1'b1;
                end
                SRC_B_HELD: begin
                    kind_reg  <= b_kind_reg;
                    num_reg   <= '0;
                    row_reg   <= b_row_reg;
                    col_reg   <= b_col_reg;
                    chunk_reg <= '0;
                    bytes_reg <= 4'd0;
                    done_reg  <= 1'b1;
                end
                default: begin
                    kind_reg  <= K_IDENT;
                    num_reg   <= '0;
                    row_reg   <= fl_row_reg;
                    col_reg   <= fl_col_reg;
                    chunk_reg <= rdata_reg & byte_mask(chunk_n);
                    bytes_reg <= chunk_n;
                    done_reg  <= chunk_final;
                end
            endcase
        end
    end

    assign m_kind         = kind_reg;
    assign m_number_value = signed'(num_reg);
    assign m_start_row    = row_reg;
    assign m_start_col    = col_reg;
    assign m_text_chunk   = chunk_reg;
    assign m_text_bytes   = bytes_reg;
    assign m_token_done   = done_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// ===== design/sll_ctrl.sv =====
`default_nettype none

module sll_ctrl
    import sll_pkg::*;
(
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  wire   m_ready,
    input  sts_t  sts,
    output cmd_t  cmd
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_RD    = 2'd1;
    localparam logic [1:0] ST_CHUNK = 2'd2;
    localparam logic [1:0] ST_TAIL  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       b_pend_reg, b_pend_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        b_pend_next = b_pend_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_ready    = out_free;
                cmd.accept = s_valid && out_free;
                if (cmd.accept) begin
                    b_pend_next = sts.b_valid;
                    if (sts.a_simple) begin
                        cmd.load = 1'b1;
                        cmd.src  = SRC_A;
                        cmd.last = !sts.b_valid;
                        if (sts.b_valid) begin
                            state_next = ST_TAIL;
                        end
                    end else if (sts.a_ident) begin
                        cmd.k_clr  = 1'b1;
                        state_next = ST_RD;
                    end else if (sts.b_valid) begin
                        cmd.load = 1'b1;
                        cmd.src  = SRC_B_NOW;
                        cmd.last = 1'b1;
                    end
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_CHUNK;
            end
            ST_CHUNK: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_CHUNK;
                    cmd.last = sts.chunk_final && !b_pend_reg;
                    if (sts.chunk_final) begin
                        cmd.wr_first = 1'b1;
                        state_next   = b_pend_reg ? ST_TAIL : ST_RUN;
                    end else begin
                        cmd.k_inc = 1'b1;
                        cmd.rd    = 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_B_HELD;
                    cmd.last   = 1'b1;
                    state_next = ST_RUN;
                end
            end
        endcase
        m_valid_next = cmd.load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
            b_pend_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            b_pend_reg  <= b_pend_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/small_language_lexer_top.sv =====
// Channel  | Handshake          | Word
// ---------+--------------------+--------------------------------------------------
// input    | s_valid / s_ready  | s_in_byte, s_end_mark
// result   | m_valid / m_ready  | m_kind, m_number_value, m_start_row, m_start_col,
//          |                    | m_text_chunk, m_text_bytes, m_token_done, m_last
//
// A byte that gives two simple results holds s_ready low until the second is loaded,
// as both leave through the single output register.
// Flushing an identifier reads the store first, then emits it as 8-byte chunks,
// and then a trailing token if one is pending.
// Reset is synchronous, active low; the identifier store needs no clearing pass.
// A stalled result register holds s_ready low until it is taken.
`default_nettype none
`include "small_language_lexer_top_defines.svh"

module small_language_lexer_top
    import sll_pkg::*;
#(
    // longest identifier held before it is cut off as ILLEGAL
    parameter int MAX_IDENT = MAX_IDENT_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [7:0]           s_in_byte,
    input  wire                  s_end_mark,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic signed [31:0]   m_number_value,
    output logic [POS_W-1:0]     m_start_row,
    output logic [POS_W-1:0]     m_start_col,
    output logic [63:0]          m_text_chunk,
    output logic [3:0]           m_text_bytes,
    output logic                 m_token_done,
    output logic                 m_last
);

    cmd_t cmd;
    sts_t sts;

    // Controller: owns the handshakes and sequences flush, chunk and tail words.
    sll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: scanner state, identifier store and the output register.
    sll_datapath #(
        .MAX_IDENT (MAX_IDENT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_in_byte      (s_in_byte),
        .s_end_mark     (s_end_mark),
        .cmd            (cmd),
        .sts            (sts),
        .m_kind         (m_kind),
        .m_number_value (m_number_value),
        .m_start_row    (m_start_row),
        .m_start_col    (m_start_col),
        .m_text_chunk   (m_text_chunk),
        .m_text_bytes   (m_text_bytes),
        .m_token_done   (m_token_done),
        .m_last         (m_last)
    );

    // A new word goes into the output register only once the old one is gone.
    `SLL_ASSERT(a_load_when_free, aclk, aresetn, cmd.load |-> (!m_valid || m_ready))
    // An identifier flush drops s_ready while its chunks are read out.
    `SLL_ASSERT_NEXT(a_flush_stalls, aclk, aresetn, cmd.accept && sts.a_ident, !s_ready)
    // Only full identifier chunks leave with the token still open.
    `SLL_ASSERT(a_open_chunk, aclk, aresetn, (m_valid && !m_token_done) |-> (m_kind == K_IDENT && m_text_bytes == 4'd8 && !m_last))

endmodule

`default_nettype wire
